// ===== rtl/itaf_pkg.sv =====
// Shared types, codes and character helpers for the integer to ASCII formatter.
package itaf_pkg;

  localparam int VALUE_BITS_DEFAULT = 64;
  localparam int DEC_BITS           = 32;
  localparam int DEC_DIGITS         = 10;
  localparam int CHAR_COUNT_W       = 5;
  localparam int QUEUE_DEPTH        = 2;

  localparam logic [7:0] ASCII_ZERO    = 8'h30;
  localparam logic [7:0] ASCII_MINUS   = 8'h2D;
  localparam logic [7:0] ASCII_UPPER_A = 8'h41;
  localparam logic [7:0] ASCII_LOWER_A = 8'h61;

  typedef enum logic [1:0] {
    CMD_SDEC = 2'd0,
    CMD_UDEC = 2'd1,
    CMD_HEXL = 2'd2,
    CMD_HEXU = 2'd3
  } cmd_t;

  typedef struct packed {
    logic neg;
    logic dec;
    logic upper;
  } fmt_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DABBLE,
    ST_SCAN,
    ST_EMIT
  } back_state_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic dec,
                                            input logic upper);
    logic [7:0] ch;
    if (dec || d < 4'd10) begin
      ch = ASCII_ZERO + {4'd0, d};
    end else if (upper) begin
      ch = ASCII_UPPER_A + {4'd0, d - 4'd10};
    end else begin
      ch = ASCII_LOWER_A + {4'd0, d - 4'd10};
    end
    return ch;
  endfunction

endpackage

// ===== rtl/itaf_front.sv =====
// Front end: accepts a request beat and classifies it into sign, base and magnitude.
module itaf_front #(
  parameter int VALUE_BITS = itaf_pkg::VALUE_BITS_DEFAULT
) (
  input  logic                   req_valid,
  output logic                   req_stall,
  input  logic [1:0]             cmd,
  input  logic [63:0]            value,
  output logic                   push_valid,
  input  logic                   push_stall,
  output itaf_pkg::fmt_ctl_t     push_ctl,
  output logic [VALUE_BITS-1:0]  push_mag
);

  logic [itaf_pkg::DEC_BITS-1:0] word;
  logic                          is_neg;

  always_comb begin
    word        = value[itaf_pkg::DEC_BITS-1:0];
    is_neg      = (cmd == itaf_pkg::CMD_SDEC) && word[itaf_pkg::DEC_BITS-1];
    push_ctl.neg   = is_neg;
    push_ctl.dec   = (cmd == itaf_pkg::CMD_SDEC) || (cmd == itaf_pkg::CMD_UDEC);
    push_ctl.upper = (cmd == itaf_pkg::CMD_HEXU);
    if (push_ctl.dec) begin
      push_mag = VALUE_BITS'(is_neg ? (~word + 1'b1) : word);
    end else begin
      push_mag = value[VALUE_BITS-1:0];
    end
  end

  assign push_valid = req_valid;
  assign req_stall  = push_stall;

endmodule

// ===== rtl/itaf_queue.sv =====
// Short queue between the front end and the converter.
module itaf_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_stall,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data
);

  localparam int DEPTH = itaf_pkg::QUEUE_DEPTH;
  localparam int PW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign push_stall = (count == CW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = entries[rd_ptr];
  assign do_push    = push_valid && !push_stall;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/itaf_back.sv =====
// Back end: binary to BCD conversion, leading digit search and character output.
module itaf_back #(
  parameter int VALUE_BITS = itaf_pkg::VALUE_BITS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                q_valid,
  input  itaf_pkg::fmt_ctl_t                  q_ctl,
  input  logic [VALUE_BITS-1:0]               q_mag,
  output logic                                q_pop,
  output logic                                chr_valid,
  input  logic                                chr_stall,
  output logic [7:0]                          char_code,
  output logic                                last,
  output logic [itaf_pkg::CHAR_COUNT_W-1:0]   char_count
);

  localparam int HEX_DIGITS = (VALUE_BITS + 3) / 4;
  localparam int NIB = (HEX_DIGITS > itaf_pkg::DEC_DIGITS) ? HEX_DIGITS
                                                           : itaf_pkg::DEC_DIGITS;
  localparam int IW  = $clog2(NIB);
  localparam int DW  = NIB * 4;
  localparam int BW  = itaf_pkg::DEC_DIGITS * 4;
  localparam int SW  = $clog2(itaf_pkg::DEC_BITS);
  localparam int CCW = itaf_pkg::CHAR_COUNT_W;

  itaf_pkg::back_state_t         state;
  itaf_pkg::back_state_t         state_next;
  itaf_pkg::fmt_ctl_t            ctl;
  logic [DW-1:0]                 digits;
  logic [itaf_pkg::DEC_BITS-1:0] bin;
  logic [SW-1:0]                 dcnt;
  logic [IW-1:0]                 idx;
  logic                          sign_pending;
  logic [CCW-1:0]                ccount;

  logic          out_load;
  logic          emitting;
  logic [BW-1:0] adj;
  logic [IW-1:0] top;
  logic [3:0]    nib;

  always_comb begin
    state_next = state;
    case (state)
      itaf_pkg::ST_IDLE: begin
        if (q_valid) begin
          state_next = q_ctl.dec ? itaf_pkg::ST_DABBLE : itaf_pkg::ST_SCAN;
        end
      end
      itaf_pkg::ST_DABBLE: begin
        if (dcnt == SW'(itaf_pkg::DEC_BITS - 1)) begin
          state_next = itaf_pkg::ST_SCAN;
        end
      end
      itaf_pkg::ST_SCAN: state_next = itaf_pkg::ST_EMIT;
      itaf_pkg::ST_EMIT: begin
        if (emitting && !sign_pending && idx == '0) begin
          state_next = itaf_pkg::ST_IDLE;
        end
      end
      default: state_next = itaf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    out_load = !chr_valid || !chr_stall;
    emitting = (state == itaf_pkg::ST_EMIT) && out_load;
    q_pop    = (state == itaf_pkg::ST_IDLE) && q_valid;
  end

  always_comb begin
    adj = digits[BW-1:0];
    for (int i = 0; i < itaf_pkg::DEC_DIGITS; i++) begin
      if (adj[i*4 +: 4] >= 4'd5) begin
        adj[i*4 +: 4] = adj[i*4 +: 4] + 4'd3;
      end
    end
  end

  always_comb begin
    top = '0;
    for (int i = 0; i < NIB; i++) begin
      if (digits[i*4 +: 4] != 4'd0) begin
        top = IW'(i);
      end
    end
    nib = digits[{idx, 2'b00} +: 4];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= itaf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      itaf_pkg::ST_IDLE: begin
        if (q_valid) begin
          ctl    <= q_ctl;
          bin    <= q_mag[itaf_pkg::DEC_BITS-1:0];
          dcnt   <= '0;
          ccount <= '0;
          digits <= q_ctl.dec ? '0 : DW'(q_mag);
        end
      end
      itaf_pkg::ST_DABBLE: begin
        digits <= DW'({adj[BW-2:0], bin[itaf_pkg::DEC_BITS-1]});
        bin    <= {bin[itaf_pkg::DEC_BITS-2:0], 1'b0};
        dcnt   <= dcnt + SW'(1);
      end
      itaf_pkg::ST_SCAN: begin
        idx          <= top;
        sign_pending <= ctl.neg;
      end
      itaf_pkg::ST_EMIT: begin
        if (emitting) begin
          ccount <= ccount + CCW'(1);
          if (sign_pending) begin
            sign_pending <= 1'b0;
          end else if (idx != '0) begin
            idx <= idx - IW'(1);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (emitting) begin
      char_code  <= sign_pending ? itaf_pkg::ASCII_MINUS
                                 : itaf_pkg::digit_char(nib, ctl.dec, ctl.upper);
      last       <= !sign_pending && (idx == '0);
      char_count <= ccount + CCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chr_valid <= 1'b0;
    end else if (out_load) begin
      chr_valid <= emitting;
    end
  end

`ifndef NO_ASSERTIONS
  a_dabble_decimal: assert property (@(posedge clk) disable iff (rst)
    state == itaf_pkg::ST_DABBLE |-> ctl.dec)
    else $error("BCD conversion running on a hex item");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    chr_valid |-> (char_count != '0) && (char_count <= CCW'(16)))
    else $error("character count out of range");

  a_pop_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> state != itaf_pkg::ST_IDLE)
    else $error("popped item not taken up");

  a_sign_only_negative: assert property (@(posedge clk) disable iff (rst)
    (state == itaf_pkg::ST_EMIT) && sign_pending |-> ctl.neg && ctl.dec)
    else $error("minus sign pending on a non-negative item");
`endif

endmodule

// ===== rtl/integer_to_ascii_formatter_top.sv =====
// Top level of the integer to ASCII formatter.
// Each request beat carries a format (signed decimal, unsigned decimal, lowercase
// or uppercase hex) and a value; the block returns one beat per character, most
// significant first, with no leading zeros, a '-' for negative signed values,
// last set on the final character and char_count counting from 1. A hex item
// goes through the scan and emit states, one character per cycle at most while
// chr_stall is low; a decimal item first goes through the one-bit-per-cycle binary
// to BCD shift. A two-entry queue behind the front end takes new requests
// while the converter is busy, so the request side stalls only when it is full.
module integer_to_ascii_formatter_top #(
  parameter int VALUE_BITS = itaf_pkg::VALUE_BITS_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              req_valid,
  output logic                              req_stall,
  input  logic [1:0]                        cmd,
  input  logic [63:0]                       value,
  output logic                              chr_valid,
  input  logic                              chr_stall,
  output logic [7:0]                        char_code,
  output logic                              last,
  output logic [itaf_pkg::CHAR_COUNT_W-1:0] char_count
);

  localparam int CTLW = $bits(itaf_pkg::fmt_ctl_t);
  localparam int QW   = CTLW + VALUE_BITS;

  logic                  push_valid;
  logic                  push_stall;
  itaf_pkg::fmt_ctl_t    push_ctl;
  logic [VALUE_BITS-1:0] push_mag;
  logic                  q_valid;
  logic                  q_pop;
  logic [QW-1:0]         q_data;
  itaf_pkg::fmt_ctl_t    q_ctl;
  logic [VALUE_BITS-1:0] q_mag;

  assign q_ctl = q_data[QW-1 -: CTLW];
  assign q_mag = q_data[VALUE_BITS-1:0];

  itaf_front #(
    .VALUE_BITS(VALUE_BITS)
  ) u_front (
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .cmd        (cmd),
    .value      (value),
    .push_valid (push_valid),
    .push_stall (push_stall),
    .push_ctl   (push_ctl),
    .push_mag   (push_mag)
  );

  itaf_queue #(
    .WIDTH(QW)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_stall (push_stall),
    .push_data  ({push_ctl, push_mag}),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_data   (q_data)
  );

  itaf_back #(
    .VALUE_BITS(VALUE_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_ctl      (q_ctl),
    .q_mag      (q_mag),
    .q_pop      (q_pop),
    .chr_valid  (chr_valid),
    .chr_stall  (chr_stall),
    .char_code  (char_code),
    .last       (last),
    .char_count (char_count)
  );

endmodule

// ===== dv/itaf_char_checker.sv =====
// Checker for the integer to ASCII formatter: predicts the characters of each number and compares.
`timescale 1ns / 1ps

module itaf_char_checker #(
  parameter int VALUE_BITS = itaf_pkg::VALUE_BITS_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              req_valid,
  input  logic                              req_stall,
  input  logic [1:0]                        cmd,
  input  logic [63:0]                       value,
  input  logic                              chr_valid,
  input  logic                              chr_stall,
  input  logic [7:0]                        char_code,
  input  logic                              last,
  input  logic [itaf_pkg::CHAR_COUNT_W-1:0] char_count,
  output int                                fail_count,
  output int                                chars_pending,
  output int                                chars_checked
);

  localparam int CCW = itaf_pkg::CHAR_COUNT_W;

  typedef struct packed {
    logic [7:0]     code;
    logic           fin;
    logic [CCW-1:0] count;
  } char_beat_t;

  localparam logic [63:0] HEX_MASK = {64{1'b1}} >> (64 - VALUE_BITS);

  char_beat_t expected_chars[$];

  initial begin
    fail_count    = 0;
    chars_checked = 0;
  end

  assign chars_pending = expected_chars.size();

  function automatic void format_number(input itaf_pkg::cmd_t fmt, input logic [63:0] num);
    logic [63:0] mag;
    logic [63:0] radix;
    logic [3:0]  digs[16];
    logic [31:0] low_word;
    logic        neg;
    logic [7:0]  ch;
    int          nd;
    int          total;
    int          k;
    char_beat_t  beat;
    neg      = 1'b0;
    low_word = num[31:0];
    case (fmt)
      itaf_pkg::CMD_SDEC: begin
        if (low_word[31]) begin
          neg      = 1'b1;
          low_word = -low_word;
        end
        mag   = {32'd0, low_word};
        radix = 64'd10;
      end
      itaf_pkg::CMD_UDEC: begin
        mag   = {32'd0, low_word};
        radix = 64'd10;
      end
      default: begin
        mag   = num & HEX_MASK;
        radix = 64'd16;
      end
    endcase
    nd = 0;
    do begin
      digs[nd] = 4'(mag % radix);
      nd++;
      mag = mag / radix;
    end while (mag != 0 && nd < 16);
    total = nd + int'(neg);
    k     = 0;
    if (neg) begin
      beat = '{code: itaf_pkg::ASCII_MINUS, fin: (total == 1), count: CCW'(1)};
      expected_chars.push_back(beat);
      k = 1;
    end
    for (int i = nd - 1; i >= 0; i--) begin
      if (digs[i] < 4'd10) begin
        ch = itaf_pkg::ASCII_ZERO + 8'(digs[i]);
      end else if (fmt == itaf_pkg::CMD_HEXU) begin
        ch = itaf_pkg::ASCII_UPPER_A + 8'(digs[i] - 4'd10);
      end else begin
        ch = itaf_pkg::ASCII_LOWER_A + 8'(digs[i] - 4'd10);
      end
      beat = '{code: ch, fin: (k + 1 == total), count: CCW'(k + 1)};
      expected_chars.push_back(beat);
      k++;
    end
  endfunction

  always @(posedge clk) begin
    char_beat_t want;
    if (!rst) begin
      if (chr_valid && !chr_stall) begin
        if (expected_chars.size() == 0) begin
          $error("unexpected character beat: char_code %h last %b char_count %0d",
                 char_code, last, char_count);
          fail_count++;
        end else begin
          want = expected_chars.pop_front();
          chars_checked++;
          if (char_code !== want.code) begin
            $error("char_code expected %h got %h", want.code, char_code);
            fail_count++;
          end
          if (last !== want.fin) begin
            $error("last expected %b got %b", want.fin, last);
            fail_count++;
          end
          if (char_count !== want.count) begin
            $error("char_count expected %0d got %0d", want.count, char_count);
            fail_count++;
          end
        end
      end
      if (req_valid && !req_stall) begin
        format_number(itaf_pkg::cmd_t'(cmd), value);
      end
    end
  end

endmodule

// ===== dv/tb_top.sv =====
// Testbench top for the integer to ASCII formatter: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;

  localparam int N_RANDOM = 100;

  logic                              clk;
  logic                              rst;
  logic                              req_valid;
  logic                              req_stall;
  logic [1:0]                        cmd;
  logic [63:0]                       value;
  logic                              chr_valid;
  logic                              chr_stall;
  logic [7:0]                        char_code;
  logic                              last;
  logic [itaf_pkg::CHAR_COUNT_W-1:0] char_count;

  int fail_count;
  int chars_pending;
  int chars_checked;
  int numbers_sent;
  bit req_idle_on;
  bit chr_stall_on;

  integer_to_ascii_formatter_top DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .cmd       (cmd),
    .value     (value),
    .chr_valid (chr_valid),
    .chr_stall (chr_stall),
    .char_code (char_code),
    .last      (last),
    .char_count(char_count)
  );

  itaf_char_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .cmd          (cmd),
    .value        (value),
    .chr_valid    (chr_valid),
    .chr_stall    (chr_stall),
    .char_code    (char_code),
    .last         (last),
    .char_count   (char_count),
    .fail_count   (fail_count),
    .chars_pending(chars_pending),
    .chars_checked(chars_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // Random stall bursts on the character side.
  initial begin
    chr_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (chr_stall_on && $urandom_range(0, 5) == 0) begin
        chr_stall <= 1'b1;
        repeat ($urandom_range(1, 6)) @(negedge clk);
        chr_stall <= 1'b0;
      end
    end
  end

  task automatic send_number(input itaf_pkg::cmd_t fmt, input logic [63:0] num);
    @(negedge clk);
    if (req_idle_on && $urandom_range(0, 3) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    req_valid <= 1'b1;
    cmd       <= fmt;
    value     <= num;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    numbers_sent++;
  endtask

  function automatic logic [63:0] random_number();
    logic [63:0] num;
    num = {$urandom, $urandom};
    case ($urandom_range(0, 4))
      0:       num = 64'($urandom_range(0, 20));
      1:       num = num >> $urandom_range(0, 63);
      2:       num = {num[63:32], 32'(-$urandom_range(1, 20))};
      3:       num = {num[63:32], 32'h8000_0000 ^ 32'($urandom_range(0, 3))};
      default: num = num;
    endcase
    return num;
  endfunction

  initial begin
    itaf_pkg::cmd_t fmt;
    rst          = 1'b1;
    req_valid    = 1'b0;
    cmd          = itaf_pkg::CMD_SDEC;
    value        = '0;
    numbers_sent = 0;
    req_idle_on  = 1'b0;
    chr_stall_on = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // zero and all ones in every format, then the signed extremes and other edge values
    for (int f = 0; f <= 3; f++) begin
      send_number(itaf_pkg::cmd_t'(f), 64'd0);
      send_number(itaf_pkg::cmd_t'(f), 64'hFFFF_FFFF_FFFF_FFFF);
    end
    send_number(itaf_pkg::CMD_SDEC, 64'h0000_0000_8000_0000);
    send_number(itaf_pkg::CMD_SDEC, 64'h0000_0000_7FFF_FFFF);
    send_number(itaf_pkg::CMD_SDEC, 64'h1234_5678_FFFF_FFF6);
    send_number(itaf_pkg::CMD_UDEC, 64'h0000_0000_8000_0000);
    send_number(itaf_pkg::CMD_UDEC, 64'hDEAD_BEEF_0000_0000);
    send_number(itaf_pkg::CMD_SDEC, 64'hFFFF_FFFF_0000_007B);
    send_number(itaf_pkg::CMD_UDEC, 64'd9);
    send_number(itaf_pkg::CMD_UDEC, 64'd10);
    send_number(itaf_pkg::CMD_HEXL, 64'd15);
    send_number(itaf_pkg::CMD_HEXU, 64'd16);
    send_number(itaf_pkg::CMD_HEXL, 64'h0123_4567_89AB_CDEF);
    send_number(itaf_pkg::CMD_HEXU, 64'hFEDC_BA98_7654_3210);
    send_number(itaf_pkg::CMD_HEXU, 64'h8000_0000_0000_0000);

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i % 10 == 0) begin
        req_idle_on  = (i < N_RANDOM - 30) && $urandom_range(0, 2) != 0;
        chr_stall_on = (i < N_RANDOM - 30) && $urandom_range(0, 2) != 0;
      end
      fmt = itaf_pkg::cmd_t'($urandom_range(0, 3));
      send_number(fmt, random_number());
    end
    @(negedge clk);
    req_valid <= 1'b0;

    while (chars_pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    $display("Formatted %0d numbers across signed, unsigned, lower and upper hex;",
             numbers_sent);
    $display("%0d character beats compared under random idle and stall bursts.",
             chars_checked);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== integer_to_ascii_formatter_top.f =====
rtl/itaf_pkg.sv
rtl/itaf_front.sv
rtl/itaf_queue.sv
rtl/itaf_back.sv
rtl/integer_to_ascii_formatter_top.sv
dv/itaf_char_checker.sv
dv/tb_top.sv
